// ----- hw/rtl/cfr_pkg.sv -----
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared constants, types and codes of the CRC-16 frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // payload buffer depth and derived widths
  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CRC_W       = 16;

  // crc-16, reflected polynomial
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  // register reset values
  localparam logic [BYTE_W-1:0] HDR1_RST  = 8'd165;
  localparam logic [BYTE_W-1:0] HDR2_RST  = 8'd90;
  localparam logic [LEN_W-1:0]  LIMIT_RST = 7'd64;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_HDR1  = 2'd0,
    CFG_HDR2  = 2'd1,
    CFG_LIMIT = 2'd2
  } cfg_idx_e;

  // result status codes
  typedef enum logic [1:0] {
    STS_GOOD    = 2'd0,
    STS_CRC_ERR = 2'd1,
    STS_LEN_ERR = 2'd2
  } status_e;

  // frame parse position
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HDR2   = 3'd1,
    PH_LEN    = 3'd2,
    PH_ID     = 3'd3,
    PH_DATA   = 3'd4,
    PH_CRC_HI = 3'd5,
    PH_CRC_LO = 3'd6
  } phase_e;

  // sequencer states
  typedef enum logic [2:0] {
    SQ_IDLE    = 3'd0,
    SQ_CRC     = 3'd1,
    SQ_PUT     = 3'd2,
    SQ_EMIT_RD = 3'd3,
    SQ_EMIT_LD = 3'd4
  } seq_e;

  // control into the crc unit
  typedef struct packed {
    logic              init;
    logic              start;
    logic [BYTE_W-1:0] data;
  } crc_ctl_t;

endpackage

// ----- hw/rtl/cfr_ram.sv -----
// ----------------------------------------------------------------------------
// cfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/cfr_crc_unit.sv -----
// ----------------------------------------------------------------------------
// cfr_crc_unit
// Bit-serial CRC-16 engine: holds the running crc, one bit per cycle.
// ----------------------------------------------------------------------------
module cfr_crc_unit
  import cfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  crc_ctl_t         ctl_i,
  output logic [CRC_W-1:0] crc_o,
  output logic             busy_o
);

  logic [CRC_W-1:0] crc_q, crc_d;
  logic [2:0]       bit_cnt_q, bit_cnt_d;
  logic             busy_q, busy_d;

  // load, xor in a byte, or shift one bit
  always_comb begin
    crc_d     = crc_q;
    bit_cnt_d = bit_cnt_q;
    busy_d    = busy_q;
    if (ctl_i.init) begin
      crc_d  = CRC_INIT;
      busy_d = 1'b0;
    end else if (ctl_i.start) begin
      crc_d     = crc_q ^ {{(CRC_W-BYTE_W){1'b0}}, ctl_i.data};
      bit_cnt_d = 3'd0;
      busy_d    = 1'b1;
    end else if (busy_q) begin
      crc_d     = (crc_q >> 1) ^ (crc_q[0] ? CRC_POLY : '0);
      bit_cnt_d = bit_cnt_q + 3'd1;
      if (bit_cnt_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= CRC_INIT;
      bit_cnt_q <= 3'd0;
      busy_q    <= 1'b0;
    end else begin
      crc_q     <= crc_d;
      bit_cnt_q <= bit_cnt_d;
      busy_q    <= busy_d;
    end
  end

  assign crc_o  = crc_q;
  assign busy_o = busy_q;

endmodule

// ----- hw/rtl/crc16_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// crc16_frame_receiver
// Serial byte deframer: header, length, id, payload, crc-16 high then low.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / rx_byte_i) takes one received
//   byte per beat. Output channel (out_valid_o / out_stall_i) gives results:
//   the payload as a run of beats on a good crc, one marker beat for an empty
//   payload, or one error beat on crc mismatch or oversize length.
//   Config channel (cfg_valid_i / cfg_ready_o) writes header bytes and the
//   length limit; write only while the block is quiet.
// Timing:
//   a payload byte is accepted, then shifted bit by bit through the
//   bit-serial crc unit before the sequencer returns to idle; header,
//   length, id and crc bytes need a further sequencer state only when they
//   raise an error or marker beat. After the crc low byte a payload run
//   alternates SQ_EMIT_RD, the registered read of the payload RAM, and
//   SQ_EMIT_LD, the load of the output register, for each beat. No bytes
//   are taken while the sequencer is busy with a crc update or a result.
// Reset: parser idle, crc 0xFFFF, registers at their defaults; the payload
//   RAM is not cleared and needs no clearing pass.
// Stall: a stalled result holds in the output register; a run or a pending
//   result, and so the input side, wait until it is taken.
// ----------------------------------------------------------------------------
module crc16_frame_receiver
  import cfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // config write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [BYTE_W-1:0] cfg_data_i,
  // input byte channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] rx_byte_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [BYTE_W-1:0] frame_id_o,
  output logic [LEN_W-1:0]  payload_len_o,
  output logic [BYTE_W-1:0] data_byte_o,
  output logic [IDX_W-1:0]  byte_index_o,
  output logic              last_o
);

  // configuration registers
  logic [BYTE_W-1:0] hdr1_q, hdr2_q;
  logic [LEN_W-1:0]  limit_q;

  // parser state
  phase_e            phase_q, phase_d;
  seq_e              seq_q, seq_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [BYTE_W-1:0] len_q, len_d;
  logic [BYTE_W-1:0] id_q, id_d;
  logic [BYTE_W-1:0] crc_hi_q, crc_hi_d;
  status_e           res_sts_q, res_sts_d;
  logic [LEN_W-1:0]  res_len_q, res_len_d;
  logic [IDX_W-1:0]  emit_idx_q;

  // output register
  logic              out_valid_q;
  status_e           out_sts_q;
  logic [BYTE_W-1:0] out_id_q;
  logic [LEN_W-1:0]  out_len_q;
  logic [BYTE_W-1:0] out_data_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic              out_last_q;

  // control
  logic              in_acc, out_free, emit_last;
  logic              res_put, emit_go, ram_we;
  logic              load_put, load_emit;
  logic [LEN_W-1:0]  lim_eff;
  crc_ctl_t          crc_ctl;
  logic [CRC_W-1:0]  crc;
  logic              crc_busy;
  logic [BYTE_W-1:0] ram_rdata;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign lim_eff   = (limit_q > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : limit_q;
  assign emit_last = ({1'b0, emit_idx_q} + LEN_W'(1)) == cnt_q;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr1_q  <= HDR1_RST;
      hdr2_q  <= HDR2_RST;
      limit_q <= LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HDR1:  hdr1_q  <= cfg_data_i;
        CFG_HDR2:  hdr2_q  <= cfg_data_i;
        CFG_LIMIT: limit_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // frame parser: decodes one accepted byte
  always_comb begin
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    len_d        = len_q;
    id_d         = id_q;
    crc_hi_d     = crc_hi_q;
    res_sts_d    = res_sts_q;
    res_len_d    = res_len_q;
    res_put      = 1'b0;
    emit_go      = 1'b0;
    ram_we       = 1'b0;
    crc_ctl.init  = 1'b0;
    crc_ctl.start = 1'b0;
    crc_ctl.data  = rx_byte_i;
    if (in_acc) begin
      if (rx_byte_i == hdr1_q) begin
        // restart on header byte from any phase
        phase_d      = PH_HDR2;
        cnt_d        = '0;
        crc_ctl.init = 1'b1;
      end else begin
        case (phase_q)
          PH_HDR2: phase_d = (rx_byte_i == hdr2_q) ? PH_LEN : PH_IDLE;
          PH_LEN: begin
            len_d   = rx_byte_i;
            phase_d = PH_ID;
          end
          PH_ID: begin
            id_d         = rx_byte_i;
            cnt_d        = '0;
            crc_ctl.init = 1'b1;
            if (len_q > {1'b0, lim_eff}) begin
              res_put   = 1'b1;
              res_sts_d = STS_LEN_ERR;
              res_len_d = len_q[BYTE_W-1] ? {LEN_W{1'b1}} : len_q[LEN_W-1:0];
              phase_d   = PH_IDLE;
            end else begin
              phase_d = (len_q == '0) ? PH_CRC_HI : PH_DATA;
            end
          end
          PH_DATA: begin
            ram_we        = 1'b1;
            crc_ctl.start = 1'b1;
            cnt_d         = cnt_q + LEN_W'(1);
            if ({1'b0, cnt_d} >= len_q) begin
              phase_d = PH_CRC_HI;
            end
          end
          PH_CRC_HI: begin
            crc_hi_d = rx_byte_i;
            phase_d  = PH_CRC_LO;
          end
          PH_CRC_LO: begin
            phase_d = PH_IDLE;
            if ({crc_hi_q, rx_byte_i} != crc) begin
              res_put   = 1'b1;
              res_sts_d = STS_CRC_ERR;
              res_len_d = len_q[LEN_W-1:0];
            end else if (cnt_q == '0) begin
              res_put   = 1'b1;
              res_sts_d = STS_GOOD;
              res_len_d = '0;
            end else begin
              emit_go = 1'b1;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // sequencer next state
  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      SQ_IDLE: begin
        if (crc_ctl.start) begin
          seq_d = SQ_CRC;
        end else if (res_put) begin
          seq_d = SQ_PUT;
        end else if (emit_go) begin
          seq_d = SQ_EMIT_RD;
        end
      end
      SQ_CRC:     if (!crc_busy) seq_d = SQ_IDLE;
      SQ_PUT:     if (out_free) seq_d = SQ_IDLE;
      SQ_EMIT_RD: if (out_free) seq_d = SQ_EMIT_LD;
      SQ_EMIT_LD: seq_d = emit_last ? SQ_IDLE : SQ_EMIT_RD;
      default:    seq_d = SQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    load_put   = 1'b0;
    load_emit  = 1'b0;
    case (seq_q)
      SQ_IDLE:    in_stall_o = 1'b0;
      SQ_PUT:     load_put   = out_free;
      SQ_EMIT_LD: load_emit  = 1'b1;
      default: ;
    endcase
  end

  // parser and sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      seq_q      <= SQ_IDLE;
      cnt_q      <= '0;
      len_q      <= '0;
      id_q       <= '0;
      crc_hi_q   <= '0;
      res_sts_q  <= STS_GOOD;
      res_len_q  <= '0;
      emit_idx_q <= '0;
    end else begin
      phase_q   <= phase_d;
      seq_q     <= seq_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      id_q      <= id_d;
      crc_hi_q  <= crc_hi_d;
      res_sts_q <= res_sts_d;
      res_len_q <= res_len_d;
      if (emit_go) begin
        emit_idx_q <= '0;
      end else if (load_emit) begin
        emit_idx_q <= emit_idx_q + IDX_W'(1);
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_put || load_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load_put) begin
      out_sts_q  <= res_sts_q;
      out_id_q   <= id_q;
      out_len_q  <= res_len_q;
      out_data_q <= '0;
      out_idx_q  <= '0;
      out_last_q <= 1'b1;
    end else if (load_emit) begin
      out_sts_q  <= STS_GOOD;
      out_id_q   <= id_q;
      out_len_q  <= cnt_q;
      out_data_q <= ram_rdata;
      out_idx_q  <= emit_idx_q;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_sts_q;
  assign frame_id_o    = out_id_q;
  assign payload_len_o = out_len_q;
  assign data_byte_o   = out_data_q;
  assign byte_index_o  = out_idx_q;
  assign last_o        = out_last_q;

  // single bit-serial crc unit
  cfr_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (crc_ctl),
    .crc_o  (crc),
    .busy_o (crc_busy)
  );

  // payload buffer
  cfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (rx_byte_i),
    .raddr_i (emit_idx_q),
    .rdata_o (ram_rdata)
  );

endmodule
